/* rtl/lch_pkg.sv */
// Shared constants, types and helpers for the lower-case name hash block.
package lch_pkg;

	localparam int unsigned MODE_W  = 2;
	localparam int unsigned REM_W   = 32;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned PADDR_W = 3;

	localparam logic [MODE_W-1:0] MODE_C24_FF = 2'd0;
	localparam logic [MODE_W-1:0] MODE_C32    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_C24_7F = 2'd2;

	localparam logic [23:0] C24_POLY = 24'h864CFB;
	localparam logic [23:0] C24_INIT = 24'hB704CE;
	localparam logic [31:0] C32_POLY = 32'h04C11DB7;
	localparam logic [31:0] C32_INIT = 32'hFFFFFFFF;
	localparam logic [7:0]  TOP_FF   = 8'hFF;
	localparam logic [7:0]  TOP_7F   = 8'h7F;

	typedef struct packed {
		logic [MODE_W-1:0] hash_mode;
		logic              mode_wr;
	} cfg_ctl_t;

	function automatic logic [REM_W-1:0] mode_init(logic [MODE_W-1:0] mode);
		return (mode == MODE_C32) ? C32_INIT : {8'h00, C24_INIT};
	endfunction

endpackage

/* rtl/lch_cfg.sv */
// APB register file holding the hash mode select.
module lch_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lch_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output lch_pkg::cfg_ctl_t             ctl
);
	import lch_pkg::*;

	logic [MODE_W-1:0] mode_q;
	logic              wr_en;

	// Register 0 sits at byte address 0; bit 2 selects the next word.
	assign wr_en = psel && penable && pwrite && !paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_C24_FF;
		end else if (wr_en) begin
			mode_q <= pwdata[MODE_W-1:0];
		end
	end

	assign pready        = 1'b1;
	assign prdata        = paddr[2] ? 32'h0 : {{(32-MODE_W){1'b0}}, mode_q};
	assign ctl.hash_mode = mode_q;
	assign ctl.mode_wr   = wr_en;

endmodule

/* rtl/lch_crc_update.sv */
// Case fold, one-byte CRC-24/CRC-32 update and finished hash formatting.
module lch_crc_update (
	input  logic [lch_pkg::MODE_W-1:0] hash_mode,
	input  logic [lch_pkg::REM_W-1:0]  rem_in,
	input  logic [lch_pkg::BYTE_W-1:0] name_byte,
	input  logic                       carries_byte,
	output logic [lch_pkg::REM_W-1:0]  rem_out,
	output logic [lch_pkg::REM_W-1:0]  hash_out
);
	import lch_pkg::*;

	function automatic logic [23:0] crc24_byte(logic [23:0] r, logic [7:0] b);
		logic [23:0] c;
		c = r ^ {b, 16'h0000};
		for (int i = 0; i < 8; i++) begin
			c = c[23] ? ({c[22:0], 1'b0} ^ C24_POLY) : {c[22:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [31:0] crc32_byte(logic [31:0] r, logic [7:0] b);
		logic [31:0] c;
		c = r ^ {b, 24'h000000};
		for (int i = 0; i < 8; i++) begin
			c = c[31] ? ({c[30:0], 1'b0} ^ C32_POLY) : {c[30:0], 1'b0};
		end
		return c;
	endfunction

	logic [BYTE_W-1:0] folded;

	always_comb begin
		folded = name_byte;
		if (name_byte inside {[8'h41:8'h5A]}) begin
			folded = name_byte + 8'h20;
		end
	end

	always_comb begin
		rem_out = rem_in;
		if (carries_byte) begin
			if (hash_mode == MODE_C32) begin
				rem_out = crc32_byte(rem_in, folded);
			end else begin
				rem_out = {8'h00, crc24_byte(rem_in[23:0], folded)};
			end
		end
	end

	always_comb begin
		case (hash_mode)
			MODE_C32:    hash_out = rem_out;
			MODE_C24_7F: hash_out = {TOP_7F, rem_out[23:0]};
			default:     hash_out = {TOP_FF, rem_out[23:0]};
		endcase
	end

endmodule

/* rtl/lowercase_name_crc_hash.sv */
// Top level of the lower-case name hash: input stage, remainder and result register.
//
//  channel | direction | fields                                | handshake
//  in      | sink      | name_byte, carries_byte, ends_name     | in_valid / in_stall
//  out     | source    | hash_value                            | out_valid / out_stall
//  apb     | slave     | hash_mode at address 0                | psel, penable, pready
//
// One item per cycle while in_stall is low; the CRC byte update plus hash formatting
// sits between the input stage and the result register.
// A name-ending item passes the input stage, then the result register, to reach out_valid.
// Reset sets mode 0 and the CRC-24 initial remainder; a mode write reloads the remainder.
// in_stall rises only when the staged item ends a name and the result register is
// still full and stalled.
module lowercase_name_crc_hash (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [lch_pkg::BYTE_W-1:0]    name_byte,
	input  logic                          carries_byte,
	input  logic                          ends_name,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lch_pkg::REM_W-1:0]     hash_value,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lch_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import lch_pkg::*;

	cfg_ctl_t          ctl;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              carries_s1;
	logic              ends_s1;
	logic [REM_W-1:0]  rem_q;
	logic [REM_W-1:0]  rem_next;
	logic [REM_W-1:0]  hash_next;
	logic              out_valid_q;
	logic [REM_W-1:0]  hash_q;
	logic              adv_s1;
	logic              in_xfer;
	logic              out_xfer;

	lch_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.ctl     (ctl)
	);

	lch_crc_update u_upd (
		.hash_mode    (ctl.hash_mode),
		.rem_in       (rem_q),
		.name_byte    (byte_s1),
		.carries_byte (carries_s1),
		.rem_out      (rem_next),
		.hash_out     (hash_next)
	);

	// Staged item moves on unless it needs the result register and that is blocked.
	assign adv_s1   = valid_s1 && (!ends_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1    <= name_byte;
			carries_s1 <= carries_byte;
			ends_s1    <= ends_name;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= mode_init(MODE_C24_FF);
		end else if (ctl.mode_wr) begin
			rem_q <= mode_init(pwdata[MODE_W-1:0]);
		end else if (adv_s1) begin
			rem_q <= ends_s1 ? mode_init(ctl.hash_mode) : rem_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && ends_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && ends_s1) begin
			hash_q <= hash_next;
		end
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;

	a_mode_wr_reload: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.mode_wr |=> rem_q == mode_init(ctl.hash_mode))
		else $error("remainder not reloaded after mode write");

	a_c24_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.hash_mode != MODE_C32) |-> rem_q[31:24] == 8'h00)
		else $error("CRC-24 remainder has upper bits set");

	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && ends_s1) |=> out_valid)
		else $error("name end did not load the result register");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && ends_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

endmodule

/* sim/lowercase_name_crc_hash_tb.sv */
// Self-checking testbench for the lower-case name hash: directed table, random names, APB modes.
module lowercase_name_crc_hash_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lch_pkg::*;

	localparam logic [MODE_W-1:0]  MODE_SPARE     = 2'd3;
	localparam logic [PADDR_W-1:0] HASH_MODE_ADDR = 3'd0;
	localparam logic [PADDR_W-1:0] SPARE_REG_ADDR = 3'd4;
	localparam int unsigned        SETTLE_CYCLES  = 4;
	localparam int unsigned        HOLD_CYCLES    = 300;
	localparam int unsigned        LIMIT_CYCLES   = 400000;
	localparam int unsigned        PHASE_ITEMS    = 200;
	localparam int unsigned        NUM_PHASES     = 7;
	localparam int unsigned        NUM_ROWS       = 27;

	typedef enum logic [1:0] {ROW_ITEM, ROW_MODE, ROW_STRAY_REG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [7:0]  nbyte;
		logic        carries;
		logic        ends;
		logic        fixed;
		logic [31:0] hash;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [BYTE_W-1:0] name_byte = '0;
	logic carries_byte = 1'b0;
	logic ends_name = 1'b0;
	logic out_stall = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic in_stall;
	logic out_valid;
	logic [REM_W-1:0] hash_value;
	logic [31:0] prdata;
	logic pready;

	logic [MODE_W-1:0] hash_mode_shadow = MODE_C24_FF;
	logic [REM_W-1:0] remainder_shadow = {8'h00, C24_INIT};
	logic [31:0] hash_expected_q[$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned sent_items = 0;
	int unsigned burst_left = 0;
	int unsigned gap_max = 0;
	int unsigned stall_pct = 0;
	bit hold_req = 1'b0;

	always #10ns clk = ~clk;

	lowercase_name_crc_hash dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.name_byte(name_byte), .carries_byte(carries_byte), .ends_name(ends_name),
		.out_valid(out_valid), .out_stall(out_stall), .hash_value(hash_value),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	function automatic logic [REM_W-1:0] mode_seed(logic [MODE_W-1:0] mode);
		return (mode == MODE_C32) ? C32_INIT : {8'h00, C24_INIT};
	endfunction

	function automatic logic [7:0] fold_case(logic [7:0] b);
		if (b >= 8'h41 && b <= 8'h5A) begin
			return b + 8'h20;
		end
		return b;
	endfunction

	function automatic logic [23:0] crc24_update(logic [23:0] r, logic [7:0] b);
		r = r ^ {b, 16'h0000};
		for (int i = 0; i < 8; i++) begin
			r = r[23] ? ((r << 1) ^ C24_POLY) : (r << 1);
		end
		return r;
	endfunction

	function automatic logic [31:0] crc32_update(logic [31:0] r, logic [7:0] b);
		r = r ^ {b, 24'h000000};
		for (int i = 0; i < 8; i++) begin
			r = r[31] ? ((r << 1) ^ C32_POLY) : (r << 1);
		end
		return r;
	endfunction

	// Advance the shadow remainder; return 1 with the finished hash when the name ends.
	function automatic bit hash_name_item(input logic [7:0] b, input logic c, input logic e,
			output logic [31:0] hv);
		hv = '0;
		if (c) begin
			if (hash_mode_shadow == MODE_C32) begin
				remainder_shadow = crc32_update(remainder_shadow, fold_case(b));
			end else begin
				remainder_shadow = {8'h00, crc24_update(remainder_shadow[23:0], fold_case(b))};
			end
		end
		if (!e) begin
			return 1'b0;
		end
		case (hash_mode_shadow)
			MODE_C32:    hv = remainder_shadow;
			MODE_C24_7F: hv = {TOP_7F, remainder_shadow[23:0]};
			default:     hv = {TOP_FF, remainder_shadow[23:0]};
		endcase
		remainder_shadow = mode_seed(hash_mode_shadow);
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t %s: expected %08h, got %08h", $realtime, what, exp_v, got_v);
		end
	endtask

	// Result checker: compare each transfer with the oldest expected hash.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (hash_expected_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("%0t unexpected hash_value %08h", $realtime, hash_value);
				end
			end else if (hash_value !== hash_expected_q[0]) begin
				report_mismatch("hash_value", hash_expected_q.pop_front(), hash_value);
			end else begin
				void'(hash_expected_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("lowercase_name_crc_hash_tb: errors");
			$finish;
		end
	end

	// Receiver stall pattern: random runs, plus one long hold on request.
	initial begin
		int unsigned run;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else begin
				run = $urandom_range(8, 1);
				out_stall <= ($urandom_range(99) < stall_pct);
				repeat (run - 1) @(posedge clk);
			end
		end
	end

	task automatic push_item(input logic [7:0] b, input logic c, input logic e,
			input logic fixed, input logic [31:0] fixed_hash);
		logic [31:0] hv;
		in_valid <= 1'b1;
		name_byte <= b;
		carries_byte <= c;
		ends_name <= e;
		do @(posedge clk); while (in_stall);
		if (hash_name_item(b, c, e, hv)) begin
			hash_expected_q.push_back(fixed ? fixed_hash : hv);
		end
		if (c || e) begin
			sent_items++;
		end
	endtask

	// Sender pacing: bursts of random length separated by random gaps.
	task automatic pace();
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(gap_max);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(24, 1);
		end
		burst_left--;
	endtask

	task automatic wait_hashes_out();
		in_valid <= 1'b0;
		while (hash_expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == HASH_MODE_ADDR) begin
			hash_mode_shadow = data[MODE_W-1:0];
			remainder_shadow = mode_seed(data[MODE_W-1:0]);
		end
		@(posedge clk);
	endtask

	task automatic check_mode_readback();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= HASH_MODE_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {{(32 - MODE_W){1'b0}}, hash_mode_shadow}) begin
			report_mismatch("hash_mode readback", {{(32 - MODE_W){1'b0}}, hash_mode_shadow},
				prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
		wait_hashes_out();
		apb_write(addr, data);
		check_mode_readback();
	endtask

	function automatic logic [7:0] pick_char();
		case ($urandom_range(9))
			0, 1, 2, 3: return 8'h41 + 8'($urandom_range(25));
			4, 5, 6:    return 8'h61 + 8'($urandom_range(25));
			7: begin
				case ($urandom_range(3))
					0:       return 8'h40;
					1:       return 8'h5B;
					2:       return 8'h60;
					default: return 8'h7B;
				endcase
			end
			default: return 8'($urandom());
		endcase
	endfunction

	// One name: characters, idle items sprinkled in, finished by its last byte or an empty finish.
	task automatic send_name(input int unsigned max_len);
		int unsigned len;
		bit empty_finish;
		len = $urandom_range(max_len);
		empty_finish = (len == 0) || ($urandom_range(3) == 0);
		for (int unsigned i = 0; i < len; i++) begin
			if ($urandom_range(11) == 0) begin
				pace();
				push_item(8'($urandom()), 1'b0, 1'b0, 1'b0, '0);
			end
			pace();
			push_item(pick_char(), 1'b1, (i == len - 1) && !empty_finish, 1'b0, '0);
		end
		if (empty_finish) begin
			pace();
			push_item(8'($urandom()), 1'b0, 1'b1, 1'b0, '0);
		end
		// Broken sequences: stray items with random flags.
		if ($urandom_range(19) == 0) begin
			repeat ($urandom_range(4, 1)) begin
				pace();
				push_item(8'($urandom()), 1'($urandom()), 1'($urandom()), 1'b0, '0);
			end
		end
	endtask

	stim_row_t directed_rows [0:NUM_ROWS-1] = '{
		'{ROW_ITEM,      8'h00, 1'b0, 1'b1, 1'b1, 32'hFFB704CE},
		'{ROW_ITEM,      8'h41, 1'b1, 1'b0, 1'b0, 32'h0},
		'{ROW_ITEM,      8'h61, 1'b1, 1'b1, 1'b0, 32'h0},
		'{ROW_ITEM,      8'h5A, 1'b1, 1'b0, 1'b0, 32'h0},
		'{ROW_ITEM,      8'h40, 1'b1, 1'b0, 1'b0, 32'h0},
		'{ROW_ITEM,      8'h5B, 1'b1, 1'b0, 1'b0, 32'h0},
		'{ROW_ITEM,      8'h7A, 1'b1, 1'b0, 1'b0, 32'h0},
		'{ROW_ITEM,      8'hFF, 1'b1, 1'b0, 1'b0, 32'h0},
		'{ROW_ITEM,      8'hFF, 1'b0, 1'b0, 1'b0, 32'h0},
		'{ROW_ITEM,      8'h00, 1'b1, 1'b1, 1'b0, 32'h0},
		'{ROW_MODE,      8'h01, 1'b0, 1'b0, 1'b0, 32'h0},
		'{ROW_ITEM,      8'hA5, 1'b0, 1'b1, 1'b1, 32'hFFFFFFFF},
		'{ROW_ITEM,      8'h4D, 1'b1, 1'b1, 1'b0, 32'h0},
		'{ROW_ITEM,      8'h6D, 1'b1, 1'b1, 1'b0, 32'h0},
		'{ROW_ITEM,      8'h80, 1'b1, 1'b0, 1'b0, 32'h0},
		'{ROW_ITEM,      8'h01, 1'b0, 1'b1, 1'b0, 32'h0},
		'{ROW_MODE,      8'h02, 1'b0, 1'b0, 1'b0, 32'h0},
		'{ROW_ITEM,      8'h00, 1'b0, 1'b1, 1'b1, 32'h7FB704CE},
		'{ROW_ITEM,      8'h51, 1'b1, 1'b1, 1'b0, 32'h0},
		'{ROW_MODE,      8'h03, 1'b0, 1'b0, 1'b0, 32'h0},
		'{ROW_ITEM,      8'h00, 1'b0, 1'b1, 1'b1, 32'hFFB704CE},
		'{ROW_ITEM,      8'h63, 1'b1, 1'b0, 1'b0, 32'h0},
		'{ROW_MODE,      8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
		'{ROW_ITEM,      8'h00, 1'b0, 1'b1, 1'b1, 32'hFFB704CE},
		'{ROW_ITEM,      8'h78, 1'b1, 1'b0, 1'b0, 32'h0},
		'{ROW_STRAY_REG, 8'h01, 1'b0, 1'b0, 1'b0, 32'h0},
		'{ROW_ITEM,      8'h00, 1'b0, 1'b1, 1'b0, 32'h0}
	};

	initial begin
		logic [MODE_W-1:0] phase_mode [0:NUM_PHASES-1];
		int unsigned phase_stall [0:NUM_PHASES-1];
		int unsigned phase_gap [0:NUM_PHASES-1];
		int unsigned phase_start;
		logic [MODE_W-1:0] mode;

		phase_mode = '{MODE_C24_FF, MODE_C32, MODE_C24_7F, MODE_SPARE, MODE_C24_FF,
			MODE_C32, MODE_C24_7F};
		phase_stall = '{0, 30, 60, 10, 0, 85, 40};
		phase_gap = '{0, 3, 0, 8, 0, 0, 5};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_mode_readback();
		foreach (directed_rows[i]) begin
			case (directed_rows[i].kind)
				ROW_MODE:      write_reg(HASH_MODE_ADDR, {24'h0, directed_rows[i].nbyte});
				ROW_STRAY_REG: write_reg(SPARE_REG_ADDR, {24'h0, directed_rows[i].nbyte});
				default: push_item(directed_rows[i].nbyte, directed_rows[i].carries,
					directed_rows[i].ends, directed_rows[i].fixed, directed_rows[i].hash);
			endcase
		end

		for (int unsigned p = 0; p < NUM_PHASES; p++) begin
			mode = (p >= 5) ? MODE_W'($urandom_range(3)) : phase_mode[p];
			// Upper data bits are don't-care for the mode register.
			write_reg(HASH_MODE_ADDR, {30'($urandom()), mode});
			if (p == 3) begin
				write_reg(SPARE_REG_ADDR, $urandom());
			end
			stall_pct = phase_stall[p];
			gap_max = phase_gap[p];
			burst_left = 0;
			phase_start = sent_items;
			if (p == 4) begin
				// Long receiver hold with back-to-back short names fills the pipe.
				hold_req = 1'b1;
				while (sent_items - phase_start < PHASE_ITEMS) begin
					send_name(2);
				end
			end else begin
				while (sent_items - phase_start < PHASE_ITEMS) begin
					send_name(12);
				end
			end
		end

		wait_hashes_out();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("lowercase_name_crc_hash_tb: clean");
		end else begin
			$display("lowercase_name_crc_hash_tb: errors");
		end
		$finish;
	end

endmodule
